>>> rtl/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types and constants for the text console cell buffer.
// ----------------------------------------------------------------------------
package tcb_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_FILLER = 8'hFF;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [5:0] ROWS_RST = 6'd32;
  localparam logic [6:0] COLS_RST = 7'd64;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [5:0] read_col;
  } tcb_in_t;

  typedef struct packed {
    logic [5:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_byte;
  } tcb_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_OP,
    ST_RDWAIT,
    ST_FILL,
    ST_SCANCHK,
    ST_LIMIT,
    ST_SCRD,
    ST_SCWR,
    ST_DONE
  } tcb_state_t;

endpackage

>>> rtl/text_console_cell_buffer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_buffer_unit
// Character-cell console: byte store with cursor, put and read requests.
// ----------------------------------------------------------------------------
// Newline fills the rest of the row with filler; a backspace that wraps walks
// back over filler on the row above. A scroll copies rows up and clears the last
// row; a form feed sweeps the whole store to zero.
// One item at a time; the next is taken once the result sits in the output reg.
// After reset the store is swept to zero (all MAX_ROWS*MAX_COLS cells, 2048 by
// default) with in_stall high; configuration writes are taken meanwhile.
module text_console_cell_buffer_unit
  import tcb_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tcb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tcb_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int PW    = NRW + NCW;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  tcb_state_t state_r, state_nxt;
  tcb_in_t    item_r;
  tcb_out_t   out_data_r;
  logic       out_valid_r;
  logic       ff_r;
  logic [XW-1:0]  cx_r;
  logic [YW-1:0]  cy_r;
  logic [5:0]     rows_cfg_r;
  logic [6:0]     cols_cfg_r;
  logic [PW-1:0]  prod_r;
  logic [PW-1:0]  lim_r;
  logic [PW-1:0]  k_r;
  logic [NCW-1:0] fx_r;
  logic [7:0]     byte_r;

  logic [NRW-1:0] r_eff, new_r;
  logic [NCW-1:0] c_eff, new_c;
  logic [PW-1:0]  mul_row, tot;
  logic [NCW-1:0] cx_n;
  logic [NRW-1:0] cy_n;
  logic           rd_in_range, bs_wrap, last_cell, free_out, scan_more;
  logic [XW+5:0]  cx_w;
  logic [YW+4:0]  cy_w;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  function automatic logic [NRW-1:0] eff_rows(input logic [5:0] v);
    if (v == 6'd0) return NRW'(1);
    if (int'(v) > MAX_ROWS) return NRW'(MAX_ROWS);
    return NRW'(v);
  endfunction

  function automatic logic [NCW-1:0] eff_cols(input logic [6:0] v);
    if (v == 7'd0) return NCW'(1);
    if (int'(v) > MAX_COLS) return NCW'(MAX_COLS);
    return NCW'(v);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] base,
                                              input logic [NCW-1:0] col);
    return AW'(base + PW'(col));
  endfunction

  assign r_eff = eff_rows(rows_cfg_r);
  assign c_eff = eff_cols(cols_cfg_r);
  assign new_r = (cfg_index == CFG_ROWS) ? eff_rows(cfg_wdata[5:0]) : r_eff;
  assign new_c = (cfg_index == CFG_COLS) ? eff_cols(cfg_wdata) : c_eff;

  assign cx_n        = NCW'(cx_r);
  assign cy_n        = NRW'(cy_r);
  assign tot         = lim_r + PW'(c_eff);
  assign rd_in_range = (item_r.read_row < r_eff) && (item_r.read_col < c_eff);
  assign bs_wrap     = (cx_r == '0) && (cy_r != '0);
  assign last_cell   = (cx_n + NCW'(1) == c_eff) && (cy_n + NRW'(1) == r_eff);
  assign free_out    = !out_valid_r || !out_stall;
  assign scan_more   = (mem_rdata == CH_FILLER) && (fx_r != '0);

  always_comb begin
    if (item_r.req_type == REQ_READ) begin
      mul_row = PW'(item_r.read_row);
    end else if (item_r.char_code == CH_BS && bs_wrap) begin
      mul_row = PW'(cy_r - YW'(1));
    end else begin
      mul_row = PW'(cy_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (k_r == PW'(CELLS - 1)) state_nxt = ff_r ? ST_DONE : ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = ST_BASE;
      ST_BASE:    state_nxt = ST_OP;
      ST_OP: begin
        if (item_r.req_type == REQ_READ) begin
          state_nxt = rd_in_range ? ST_RDWAIT : ST_DONE;
        end else begin
          case (item_r.char_code)
            CH_NUL: state_nxt = ST_DONE;
            CH_FF:  state_nxt = ST_CLEAR;
            CH_NL:  state_nxt = ST_FILL;
            CH_BS:  state_nxt = bs_wrap ? ST_SCANCHK : ST_DONE;
            default: state_nxt = last_cell ? ST_LIMIT : ST_DONE;
          endcase
        end
      end
      ST_RDWAIT:  state_nxt = ST_DONE;
      ST_FILL: begin
        if (fx_r >= c_eff) begin
          state_nxt = (cy_n + NRW'(1) >= r_eff) ? ST_LIMIT : ST_DONE;
        end
      end
      ST_SCANCHK: if (!scan_more) state_nxt = ST_DONE;
      ST_LIMIT:   state_nxt = ST_SCRD;
      ST_SCRD: begin
        if (k_r < lim_r) begin
          state_nxt = ST_SCWR;
        end else if (k_r >= tot) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCWR:    state_nxt = ST_SCRD;
      ST_DONE:    if (free_out) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Store port controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 8'd0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(k_r);
      end
      ST_OP: begin
        if (item_r.req_type == REQ_READ) begin
          mem_re    = rd_in_range;
          mem_raddr = cell_addr(prod_r, NCW'(item_r.read_col));
        end else begin
          case (item_r.char_code)
            CH_NUL, CH_FF: ;
            CH_NL: begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(prod_r, cx_n);
              mem_wdata = CH_NL;
            end
            CH_BS: begin
              if (cx_r != '0) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(prod_r, cx_n - NCW'(1));
              end else if (bs_wrap) begin
                mem_re    = 1'b1;
                mem_raddr = cell_addr(prod_r, c_eff - NCW'(1));
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(prod_r, '0);
              end
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(prod_r, cx_n);
              mem_wdata = item_r.char_code;
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we    = (fx_r < c_eff);
        mem_waddr = cell_addr(prod_r, fx_r);
        mem_wdata = CH_FILLER;
      end
      ST_SCANCHK: begin
        if (scan_more) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(prod_r, fx_r - NCW'(1));
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(prod_r, fx_r);
        end
      end
      ST_SCRD: begin
        if (k_r < lim_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(k_r + PW'(c_eff));
        end else if (k_r < tot) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(k_r);
        end
      end
      ST_SCWR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(k_r);
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      k_r         <= '0;
      ff_r        <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      rows_cfg_r  <= ROWS_RST;
      cols_cfg_r  <= COLS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && free_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows_cfg_r <= cfg_wdata[5:0];
        else                       cols_cfg_r <= cfg_wdata;
        if (cx_n >= new_c) cx_r <= XW'(new_c - NCW'(1));
        if (cy_n >= new_r) cy_r <= YW'(new_r - NRW'(1));
      end

      case (state_r)
        ST_CLEAR: k_r <= k_r + PW'(1);
        ST_IDLE: begin
          item_r <= in_data;
          byte_r <= 8'd0;
        end
        ST_BASE: prod_r <= mul_row * PW'(c_eff);
        ST_OP: begin
          if (item_r.req_type == REQ_PUT) begin
            case (item_r.char_code)
              CH_NUL: ;
              CH_FF: begin
                k_r  <= '0;
                ff_r <= 1'b1;
                cx_r <= '0;
                cy_r <= '0;
              end
              CH_NL: fx_r <= cx_n + NCW'(1);
              CH_BS: begin
                if (cx_r != '0) begin
                  cx_r <= cx_r - XW'(1);
                end else if (bs_wrap) begin
                  cy_r <= cy_r - YW'(1);
                  fx_r <= c_eff - NCW'(1);
                end
              end
              default: begin
                if (last_cell) begin
                  cx_r <= '0;
                end else if (cx_n + NCW'(1) == c_eff) begin
                  cx_r <= '0;
                  cy_r <= cy_r + YW'(1);
                end else begin
                  cx_r <= cx_r + XW'(1);
                end
              end
            endcase
          end
        end
        ST_RDWAIT: byte_r <= mem_rdata;
        ST_FILL: begin
          if (fx_r < c_eff) begin
            fx_r <= fx_r + NCW'(1);
          end else begin
            cx_r <= '0;
            if (cy_n + NRW'(1) < r_eff) cy_r <= cy_r + YW'(1);
          end
        end
        ST_SCANCHK: begin
          // walk back over filler, stop at column zero
          if (scan_more) fx_r <= fx_r - NCW'(1);
          else           cx_r <= XW'(fx_r);
        end
        ST_LIMIT: begin
          lim_r <= PW'(r_eff - NRW'(1)) * PW'(c_eff);
          k_r   <= '0;
        end
        ST_SCRD: if (k_r >= lim_r && k_r < tot) k_r <= k_r + PW'(1);
        ST_SCWR: k_r <= k_r + PW'(1);
        ST_DONE: begin
          if (free_out) begin
            out_data_r  <= '{cursor_col: cx_w[5:0], cursor_row: cy_w[4:0],
                             cell_byte: byte_r};
            ff_r        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign cx_w = {6'd0, cx_r};
  assign cy_w = {5'd0, cy_r};

  tcb_store #(
    .AW    (AW),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/tcb_store.sv
// ----------------------------------------------------------------------------
// tcb_store
// Cell byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcb_store #(
  parameter int AW    = 11,
  parameter int DEPTH = 2048
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tcb_checker.sv
// ----------------------------------------------------------------------------
// tcb_checker
// Port-level checks for the console cell buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tcb_checker
  import tcb_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input tcb_out_t out_data
);

  // held beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result beat changed while stalled");

  // store sweep after reset blocks input
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during reset sweep");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

endmodule

bind text_console_cell_buffer_unit tcb_checker u_tcb_checker (.*);
